### rtl/core/modexp_pkg.sv
`default_nettype none

package modexp_pkg;

  // Configuration register map
  localparam int CFG_IDX_W = 1;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_MODULUS  = 1'b0;
  localparam cfg_idx_t REG_EXPONENT = 1'b1;

endpackage

`default_nettype wire

### rtl/core/modexp_if.sv
`default_nettype none

interface modexp_cfg_if #(
  parameter int OPERAND_WIDTH = 32
);
  logic                     valid;
  logic                     ready;
  modexp_pkg::cfg_idx_t     index;
  logic [OPERAND_WIDTH-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

interface modexp_base_if #(
  parameter int OPERAND_WIDTH = 32
);
  logic                     valid;
  logic                     ready;
  logic [OPERAND_WIDTH-1:0] base;

  modport source (output valid, base, input ready);
  modport sink   (input valid, base, output ready);
endinterface

interface modexp_result_if #(
  parameter int OPERAND_WIDTH = 32
);
  logic                     valid;
  logic                     ready;
  logic [OPERAND_WIDTH-1:0] power_result;

  modport source (output valid, power_result, input ready);
  modport sink   (input valid, power_result, output ready);
endinterface

`default_nettype wire

### rtl/core/modular_exponentiation_core.sv
// Modular exponentiation core: power_result = base ** exponent mod modulus.
// Channels: cfg_i writes the modulus (index 0) and the exponent (index 1); it is
// always ready and should only be used while the core is idle. base_i takes one
// base per transaction, result_o returns one power_result per base, in order.
// All arithmetic runs on one shared modular multiply-add step unit that handles
// one multiplier bit per cycle (one doubling, one conditional add, one reduction).
// Each base is first reduced, then every exponent bit costs a squaring plus a
// multiply if the bit is one; a modulus below two skips this and gives zero.
// base_i is ready only while the sequencer is idle, one base at a time, so a new
// base is taken at the earliest in the cycle the previous result turns valid.
// The result sits in an output register; a new base is taken while it waits,
// and a finished result holds in the sequencer until the register frees up.
// Reset sets modulus to 2, exponent to 0 and drops any work in progress.
`default_nettype none

module modular_exponentiation_core #(
  parameter int OPERAND_WIDTH = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  modexp_cfg_if.sink               cfg_i,
  modexp_base_if.sink              base_i,
  modexp_result_if.source          result_o
);
  import modexp_pkg::*;

  localparam int W   = OPERAND_WIDTH;
  localparam int CW  = $clog2(W);
  localparam int TW  = W + 3;

  localparam logic [CW-1:0] STEP_LAST = CW'(W - 1);
  localparam logic [W-1:0]  ONE       = {{(W-1){1'b0}}, 1'b1};

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_REDUCE = 3'd1;
  localparam logic [2:0] ST_MUL    = 3'd2;
  localparam logic [2:0] ST_SQR    = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  logic [W-1:0]  modulus_q, modulus_d;
  logic [W-1:0]  exponent_q, exponent_d;
  logic [2:0]    state_q, state_d;
  logic [CW-1:0] step_q, step_d;
  logic [CW-1:0] bit_q, bit_d;
  logic [W-1:0]  acc_q, acc_d;
  logic [W-1:0]  ysh_q, ysh_d;
  logic [W-1:0]  base_q, base_d;
  logic [W-1:0]  res_q, res_d;
  logic          out_valid_q, out_valid_d;
  logic [W-1:0]  out_data_q, out_data_d;

  logic          mod_small;
  logic [W-1:0]  x_op;
  logic [W-1:0]  addend;
  logic [TW-1:0] sum_t;
  logic [TW-1:0] sub1;
  logic [TW-1:0] sub2;
  logic [W-1:0]  unit_out;
  logic [CW-1:0] next_bit;

  assign mod_small = (modulus_q[W-1:1] == '0);
  assign next_bit  = bit_q + 1'b1;

  // Shared step unit: acc <- (2*acc + ybit*x) mod m, with acc < m and x < m
  assign x_op     = (state_q == ST_REDUCE) ? ONE : base_q;
  assign addend   = ysh_q[W-1] ? x_op : '0;
  assign sum_t    = {2'b00, acc_q, 1'b0} + {3'b000, addend};
  assign sub1     = sum_t - {3'b000, modulus_q};
  assign sub2     = sum_t - {2'b00, modulus_q, 1'b0};
  assign unit_out = !sub2[TW-1] ? sub2[W-1:0] :
                    !sub1[TW-1] ? sub1[W-1:0] : sum_t[W-1:0];

  // Configuration register file
  assign cfg_i.ready = 1'b1;

  always_comb begin
    modulus_d  = modulus_q;
    exponent_d = exponent_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_MODULUS:  modulus_d  = cfg_i.data;
        REG_EXPONENT: exponent_d = cfg_i.data;
        default: ;
      endcase
    end
  end

  assign base_i.ready          = (state_q == ST_IDLE);
  assign result_o.valid        = out_valid_q;
  assign result_o.power_result = out_data_q;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    bit_d       = bit_q;
    acc_d       = acc_q;
    ysh_d       = ysh_q;
    base_d      = base_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;

    if (out_valid_q && result_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (base_i.valid) begin
          if (mod_small) begin
            res_d   = '0;
            state_d = ST_DONE;
          end else begin
            // reduce the base as base * 1 mod m on the step unit
            acc_d   = '0;
            ysh_d   = base_i.base;
            step_d  = STEP_LAST;
            state_d = ST_REDUCE;
          end
        end
      end
      ST_REDUCE, ST_MUL, ST_SQR: begin
        acc_d  = unit_out;
        ysh_d  = {ysh_q[W-2:0], 1'b0};
        step_d = step_q - 1'b1;
        if (step_q == '0) begin
          acc_d  = '0;
          step_d = STEP_LAST;
          case (state_q)
            ST_REDUCE: begin
              base_d = unit_out;
              res_d  = ONE;
              bit_d  = '0;
              if (exponent_q[0]) begin
                state_d = ST_MUL;
                ysh_d   = ONE;
              end else begin
                state_d = ST_SQR;
                ysh_d   = unit_out;
              end
            end
            ST_MUL: begin
              res_d   = unit_out;
              state_d = ST_SQR;
              ysh_d   = base_q;
            end
            default: begin
              base_d = unit_out;
              if (bit_q == STEP_LAST) begin
                state_d = ST_DONE;
              end else begin
                bit_d = next_bit;
                if (exponent_q[next_bit]) begin
                  state_d = ST_MUL;
                  ysh_d   = res_q;
                end else begin
                  state_d = ST_SQR;
                  ysh_d   = unit_out;
                end
              end
            end
          endcase
        end
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || result_o.ready) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q   <= W'(2);
      exponent_q  <= '0;
      state_q     <= ST_IDLE;
      step_q      <= '0;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      modulus_q   <= modulus_d;
      exponent_q  <= exponent_d;
      state_q     <= state_d;
      step_q      <= step_d;
      bit_q       <= bit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q      <= acc_d;
    ysh_q      <= ysh_d;
    base_q     <= base_d;
    res_q      <= res_d;
    out_data_q <= out_data_d;
  end

endmodule

`default_nettype wire

### rtl/core/modexp_checker.sv
`default_nettype none

module modexp_checker #(
  parameter int OPERAND_WIDTH = 32
) (
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     base_valid_i,
  input wire logic                     base_ready_i,
  input wire logic                     result_valid_i,
  input wire logic                     result_ready_i,
  input wire logic [OPERAND_WIDTH-1:0] power_result_i
);

  // A pending result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_i && !result_ready_i |=> result_valid_i)
    else $error("result dropped while stalled");

  // A pending result keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_i && !result_ready_i |=> $stable(power_result_i))
    else $error("result changed while stalled");

  // The core goes busy right after taking a base
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    base_valid_i && base_ready_i |=> !base_ready_i)
    else $error("base taken while previous base still in work");

  // A new result only appears out of a busy period
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(result_valid_i) |-> !$past(base_ready_i))
    else $error("result appeared without a base in work");

endmodule

bind modular_exponentiation_core modexp_checker #(
  .OPERAND_WIDTH(OPERAND_WIDTH)
) u_modexp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .base_valid_i  (base_i.valid),
  .base_ready_i  (base_i.ready),
  .result_valid_i(result_o.valid),
  .result_ready_i(result_o.ready),
  .power_result_i(result_o.power_result)
);

`default_nettype wire

### dv/testbench.sv
`default_nettype none

module testbench;
  import modexp_pkg::*;

  localparam int W             = 32;
  localparam int HALF_PERIOD   = 10;
  localparam int STALL_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 2100;
  localparam int RANDOM_BASES  = 268;

  typedef enum logic [1:0] {
    STEP_BASE,
    STEP_CONFIG,
    STEP_DRAIN
  } step_kind_e;

  typedef struct {
    step_kind_e     kind;
    cfg_idx_t       index;
    logic [W-1:0]   value;
  } step_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  modexp_cfg_if    #(.OPERAND_WIDTH(W)) cfg_bus ();
  modexp_base_if   #(.OPERAND_WIDTH(W)) base_bus ();
  modexp_result_if #(.OPERAND_WIDTH(W)) result_bus ();

  modular_exponentiation_core #(
    .OPERAND_WIDTH(W)
  ) i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_bus),
    .base_i   (base_bus),
    .result_o (result_bus)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  step_t        pending_steps[$];
  logic [W-1:0] expected_powers[$];
  logic [W-1:0] modulus_q;
  logic [W-1:0] exponent_q;
  int           bases_accepted  = 0;
  int           cfg_writes      = 0;
  int           results_checked = 0;
  int           error_count     = 0;
  int           quiet_cycles    = 0;

  // base ** exponent mod modulus, square-and-multiply from the low exponent bit
  function automatic logic [W-1:0] predict_power(logic [W-1:0] base, logic [W-1:0] expo,
                                                 logic [W-1:0] modulus);
    logic [2*W-1:0] m;
    logic [2*W-1:0] b;
    logic [2*W-1:0] acc;
    if (modulus < 2) return '0;
    m   = modulus;
    b   = base % m;
    acc = 1;
    for (int i = 0; i < W; i++) begin
      if (expo[i]) acc = (acc * b) % m;
      b = (b * b) % m;
    end
    return acc[W-1:0];
  endfunction

  // receiver idles more first, then the sender, then neither
  function automatic int idle_percent(bit receiver);
    if (bases_accepted < 100) return receiver ? 46 : 37;
    if (bases_accepted < 200) return receiver ? 37 : 46;
    return 0;
  endfunction

  task automatic push_base(logic [W-1:0] value);
    step_t s;
    s.kind  = STEP_BASE;
    s.index = REG_MODULUS;
    s.value = value;
    pending_steps = {pending_steps, s};
  endtask

  // drain the core, then rewrite both registers
  task automatic push_setting(logic [W-1:0] modulus, logic [W-1:0] expo);
    step_t s;
    s.kind  = STEP_DRAIN;
    s.index = REG_MODULUS;
    s.value = '0;
    pending_steps = {pending_steps, s};
    s.kind  = STEP_CONFIG;
    s.value = modulus;
    pending_steps = {pending_steps, s};
    s.index = REG_EXPONENT;
    s.value = expo;
    pending_steps = {pending_steps, s};
  endtask

  always @(posedge clk_i) begin : drive_steps
    logic base_done;
    logic cfg_done;
    logic base_valid_n;
    logic cfg_valid_n;
    if (!rst_ni) begin
      base_bus.valid <= 1'b0;
      cfg_bus.valid  <= 1'b0;
      modulus_q      = 2;
      exponent_q     = '0;
    end else begin
      base_done    = base_bus.valid && base_bus.ready;
      cfg_done     = cfg_bus.valid && cfg_bus.ready;
      base_valid_n = base_bus.valid && !base_done;
      cfg_valid_n  = cfg_bus.valid && !cfg_done;
      if (cfg_done) begin
        case (cfg_bus.index)
          REG_MODULUS:  modulus_q = cfg_bus.data;
          REG_EXPONENT: exponent_q = cfg_bus.data;
          default: ;
        endcase
        cfg_writes++;
      end
      if (base_done) begin
        expected_powers = {expected_powers,
                           predict_power(base_bus.base, exponent_q, modulus_q)};
        bases_accepted++;
      end
      if (!base_valid_n && !cfg_valid_n && pending_steps.size() > 0) begin
        case (pending_steps[0].kind)
          STEP_BASE: begin
            if ($urandom_range(99) >= idle_percent(1'b0)) begin
              base_valid_n  = 1'b1;
              base_bus.base <= pending_steps[0].value;
              void'(pending_steps.pop_front());
            end
          end
          STEP_CONFIG: begin
            cfg_valid_n   = 1'b1;
            cfg_bus.index <= pending_steps[0].index;
            cfg_bus.data  <= pending_steps[0].value;
            void'(pending_steps.pop_front());
          end
          default: begin
            // hold until every outstanding result is back
            if (expected_powers.size() == 0) void'(pending_steps.pop_front());
          end
        endcase
      end
      base_bus.valid <= base_valid_n;
      cfg_bus.valid  <= cfg_valid_n;
    end
  end

  always @(posedge clk_i) begin : check_results
    logic [W-1:0] want;
    if (!rst_ni) begin
      result_bus.ready <= 1'b0;
    end else begin
      if (result_bus.valid && result_bus.ready) begin
        if (expected_powers.size() == 0) begin
          $error("power_result transaction with no base outstanding: actual %0h",
                 result_bus.power_result);
          error_count++;
        end else begin
          want = expected_powers.pop_front();
          if (result_bus.power_result !== want) begin
            $error("power_result mismatch: expected %0h, actual %0h",
                   want, result_bus.power_result);
            error_count++;
          end
          results_checked++;
        end
      end
      result_bus.ready <= ($urandom_range(99) >= idle_percent(1'b1));
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (base_bus.valid && base_bus.ready) || (cfg_bus.valid && cfg_bus.ready)
        || (result_bus.valid && result_bus.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout after %0d cycles without a transaction", STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    logic [W-1:0] modulus;
    logic [W-1:0] expo;
    logic [W-1:0] value;
    int           queued;
    int           run_len;
    int           missing;

    rst_ni = 1'b0;

    // modulus below two always gives zero
    push_setting(32'd0, 32'd5);
    push_base(32'd0);
    push_base(32'hFFFF_FFFF);
    push_setting(32'd1, 32'hFFFF_FFFF);
    push_base(32'd1);
    push_base(32'h8000_0000);
    // zero exponent gives one, also for a base that reduces to zero
    push_setting(32'hFFFF_FFFF, 32'd0);
    push_base(32'd0);
    push_base(32'hFFFF_FFFF);
    push_base(32'h1234_5678);
    // all exponent bits set, large prime modulus, base above modulus
    push_setting(32'hFFFF_FFFB, 32'hFFFF_FFFF);
    push_base(32'd0);
    push_base(32'd1);
    push_base(32'hFFFF_FFFA);
    push_base(32'hFFFF_FFFF);
    push_base(32'd2);
    push_setting(32'd2, 32'd1);
    push_base(32'd0);
    push_base(32'd1);
    push_base(32'hFFFF_FFFF);
    push_setting(32'd3, 32'd2);
    push_base(32'd5);
    push_base(32'd2);
    push_setting(32'h8000_0000, 32'h0001_0001);
    push_base(32'h7FFF_FFFF);
    push_base(32'h8000_0001);
    push_base(32'd3);

    queued = 0;
    while (queued < RANDOM_BASES) begin
      case ($urandom_range(9))
        0:       modulus = $urandom_range(1);
        1, 2:    modulus = $urandom_range(255, 3);
        3:       modulus = 32'hFFFF_FFFF;
        4:       modulus = $urandom_range(65535, 2);
        default: modulus = $urandom;
      endcase
      case ($urandom_range(3))
        0:       expo = '0;
        1:       expo = 32'hFFFF_FFFF;
        2:       expo = $urandom_range(16, 1);
        default: expo = $urandom;
      endcase
      push_setting(modulus, expo);
      run_len = $urandom_range(30, 10);
      for (int n = 0; n < run_len; n++) begin
        case ($urandom_range(5))
          0:       value = (modulus > 1) ? $urandom_range(modulus - 1) : 32'd0;
          1:       value = modulus - 1;
          2:       value = 32'hFFFF_FFFF;
          default: value = $urandom;
        endcase
        push_base(value);
      end
      queued += run_len;
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_steps.size() != 0 || base_bus.valid || expected_powers.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    missing = expected_powers.size();
    if (missing != 0) begin
      $error("%0d power_result transactions never arrived", missing);
    end
    $display("Checked %0d results from %0d bases over %0d register writes,",
             results_checked, bases_accepted, cfg_writes);
    $display("moduli from zero to all ones, exponents from zero to all ones.");
    if (error_count == 0 && missing == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
